// ===== rtl/core/form_urlencoded_decoder_core_defines.svh =====
// assertion macros used by the decoder rtl queue
`ifndef FORM_URLENCODED_DECODER_CORE_DEFINES_SVH
`define FORM_URLENCODED_DECODER_CORE_DEFINES_SVH

// property must hold in the same cycle as its trigger
`define FUD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// property must hold in the cycle after its trigger
`define FUD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fud_pkg.sv =====
`default_nettype none

package fud_pkg;

	// result kinds
	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// results per input byte and queue sizing
	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int SLOT_IDX_W  = $clog2(MAX_RESULTS);
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic       pair_has_value;
		logic       last_of_run;
	} out_item_t;

	// one result without its run marker
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       has_value;
	} slot_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [CNT_W-1:0]               count;
		slot_t [MAX_RESULTS-1:0]        slot;
	} rec_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/fud_front.sv =====
`default_nettype none

module fud_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire fud_pkg::in_item_t  byte_item,
	input  wire fud_pkg::q_stat_t   qstat,
	output logic                    push,
	output fud_pkg::rec_t           rec
);

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_PCT   = 2'd1;
	localparam logic [1:0] PEND_DIGIT = 2'd2;

	logic [1:0] pend_q;
	logic [7:0] held_q;
	logic       inv_q;
	logic       tok_q;

	logic [1:0] pend_d;
	logic [7:0] held_d;
	logic       inv_d;
	logic       tok_d;
	logic       done;
	logic       accept;
	logic [7:0] c;
	fud_pkg::rec_t r;

	function automatic logic is_hex(input logic [7:0] ch);
		return (ch >= CH_0 && ch <= CH_9) || (ch >= CH_LA && ch <= CH_LF) ||
			(ch >= CH_UA && ch <= CH_UF);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] ch);
		logic [7:0] t;
		if (ch >= CH_LA) begin
			t = ch - CH_LA + 8'd10;
		end else if (ch >= CH_UA) begin
			t = ch - CH_UA + 8'd10;
		end else begin
			t = ch - CH_0;
		end
		return t[3:0];
	endfunction

	function automatic fud_pkg::rec_t add(input fud_pkg::rec_t ri, input logic [1:0] kind,
			input logic [7:0] data, input logic hv);
		fud_pkg::rec_t ro;
		ro = ri;
		ro.slot[ri.count[fud_pkg::SLOT_IDX_W-1:0]] = '{kind: kind, data: data, has_value: hv};
		ro.count = ri.count + fud_pkg::CNT_W'(1);
		return ro;
	endfunction

	function automatic logic [1:0] part(input logic v);
		return v ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY;
	endfunction

	assign c          = byte_item.in_byte;
	assign byte_stall = qstat.full;
	assign accept     = byte_valid && !qstat.full;

	// classify the byte and collect every result it causes
	always_comb begin
		pend_d = pend_q;
		held_d = held_q;
		inv_d  = inv_q;
		tok_d  = tok_q;
		done   = 1'b0;
		r      = '0;
		if (c == CH_AMP) begin
			// raw ampersand closes the pair
			if (tok_d) begin
				if (pend_d != PEND_NONE) r = add(r, part(inv_d), CH_PCT, 1'b0);
				if (pend_d == PEND_DIGIT) r = add(r, part(inv_d), held_d, 1'b0);
				r = add(r, fud_pkg::KIND_END, 8'd0, inv_d);
			end
			pend_d = PEND_NONE;
			held_d = '0;
			inv_d  = 1'b0;
			tok_d  = 1'b0;
		end else begin
			tok_d = 1'b1;
			if (c == CH_EQ && !inv_d) begin
				// first equals sign splits key from value
				if (pend_d != PEND_NONE) r = add(r, part(inv_d), CH_PCT, 1'b0);
				if (pend_d == PEND_DIGIT) r = add(r, part(inv_d), held_d, 1'b0);
				pend_d = PEND_NONE;
				held_d = '0;
				inv_d  = 1'b1;
			end else begin
				// escape handling, broken escapes come out literally
				if (pend_d == PEND_PCT) begin
					if (is_hex(c)) begin
						held_d = c;
						pend_d = PEND_DIGIT;
						done   = 1'b1;
					end else begin
						r = add(r, part(inv_d), CH_PCT, 1'b0);
						pend_d = PEND_NONE;
						held_d = '0;
					end
				end else if (pend_d == PEND_DIGIT) begin
					if (is_hex(c)) begin
						r = add(r, part(inv_d), {hex_val(held_d), hex_val(c)}, 1'b0);
						done = 1'b1;
					end else begin
						r = add(r, part(inv_d), CH_PCT, 1'b0);
						r = add(r, part(inv_d), held_d, 1'b0);
					end
					pend_d = PEND_NONE;
					held_d = '0;
				end
				if (!done) begin
					if (c == CH_PCT) begin
						pend_d = PEND_PCT;
					end else begin
						r = add(r, part(inv_d), (c == CH_PLUS) ? CH_SPACE : c, 1'b0);
					end
				end
			end
		end
		// end of body closes whatever is still open
		if (byte_item.is_end) begin
			if (tok_d) begin
				if (pend_d != PEND_NONE) r = add(r, part(inv_d), CH_PCT, 1'b0);
				if (pend_d == PEND_DIGIT) r = add(r, part(inv_d), held_d, 1'b0);
				r = add(r, fud_pkg::KIND_END, 8'd0, inv_d);
			end
			pend_d = PEND_NONE;
			held_d = '0;
			inv_d  = 1'b0;
			tok_d  = 1'b0;
		end
	end

	assign rec  = r;
	assign push = accept && (r.count != '0);

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			held_q <= '0;
			inv_q  <= 1'b0;
			tok_q  <= 1'b0;
		end else if (accept) begin
			pend_q <= pend_d;
			held_q <= held_d;
			inv_q  <= inv_d;
			tok_q  <= tok_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fud_queue.sv =====
`default_nettype none

`include "form_urlencoded_decoder_core_defines.svh"

module fud_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire fud_pkg::rec_t  wr_rec,
	input  wire logic           pop,
	output fud_pkg::rec_t       head,
	output fud_pkg::q_stat_t    qstat
);

	fud_pkg::rec_t                 mem_q [fud_pkg::QDEPTH];
	logic [fud_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [fud_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [fud_pkg::QCNT_W-1:0]    cnt_q;

	assign qstat.full  = (cnt_q == fud_pkg::QCNT_W'(fud_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_ptr_q];

	// record storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + fud_pkg::QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + fud_pkg::QPTR_W'(1);
			if (push && !pop) begin
				cnt_q <= cnt_q + fud_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - fud_pkg::QCNT_W'(1);
			end
		end
	end

	`FUD_ASSERT_SAME(a_no_overflow, push, !qstat.full, "queue written while full")
	`FUD_ASSERT_SAME(a_no_underflow, pop, !qstat.empty, "queue read while empty")
	`FUD_ASSERT_SAME(a_ptr_level, 1'b1, (wr_ptr_q - rd_ptr_q) == cnt_q[fud_pkg::QPTR_W-1:0], "queue pointers disagree with fill level")
	`FUD_ASSERT_SAME(a_no_empty_rec, push, wr_rec.count != '0, "record without results queued")

endmodule

`default_nettype wire

// ===== rtl/core/fud_back.sv =====
`default_nettype none

module fud_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fud_pkg::rec_t     head,
	input  wire fud_pkg::q_stat_t  qstat,
	output logic                   pop,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output fud_pkg::out_item_t     res_item
);

	logic                              out_valid_q;
	fud_pkg::out_item_t                out_q;
	logic [fud_pkg::SLOT_IDX_W-1:0]    idx_q;
	logic                              load;
	logic                              last;
	fud_pkg::slot_t                    cur;

	assign load = !out_valid_q || !res_stall;
	assign cur  = head.slot[idx_q];
	assign last = ({1'b0, idx_q} == (head.count - fud_pkg::CNT_W'(1)));
	assign pop  = load && !qstat.empty && last;

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

	// output register and run position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= !qstat.empty;
			if (!qstat.empty) begin
				idx_q <= last ? '0 : idx_q + fud_pkg::SLOT_IDX_W'(1);
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load && !qstat.empty) begin
			out_q.out_kind       <= cur.kind;
			out_q.out_byte       <= cur.data;
			out_q.pair_has_value <= cur.has_value;
			out_q.last_of_run    <= last;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/form_urlencoded_decoder_core.sv =====
// path: an accepted byte's results are written into the record queue, then loaded into the output register
// throughput: one byte per cycle while the queue is not full; a byte causing k results gives k result transactions
// a four-record queue between decoder and result serialiser absorbs output stalls
// reset: decoder in key part with nothing held, queue empty, no result valid
`default_nettype none

module form_urlencoded_decoder_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire fud_pkg::in_item_t  byte_item,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output fud_pkg::out_item_t      res_item
);

	logic             push;
	logic             pop;
	fud_pkg::rec_t    wr_rec;
	fud_pkg::rec_t    head;
	fud_pkg::q_stat_t qstat;

	// byte classification and escape decoding
	fud_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.qstat      (qstat),
		.push       (push),
		.rec        (wr_rec)
	);

	// per-byte result records
	fud_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// one result transaction per cycle while the receiver does not stall
	fud_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;

	// raw bytes with a meaning to the decoder
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 32;
	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		fud_pkg::in_item_t item;
		bit       drain_first;
		int       idle_pct;
		int       stall_pct;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	fud_pkg::in_item_t  byte_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	fud_pkg::out_item_t res_item;

	stim_t     stim_q[$];
	fud_pkg::out_item_t decoded_q[$];
	fud_pkg::out_item_t run_buf[$];
	int        outstanding = 0;
	int        stall_pct = 0;
	int        cycles = 0;
	int        fails = 0;
	int        bytes_taken = 0;
	int        results_seen = 0;
	int        pairs_closed = 0;

	// stimulus settings used while the queue is filled
	int        cur_idle = 0;
	int        cur_stall = 0;
	bit        drain_next = 1'b0;

	// decoder state of the predictor
	logic [1:0] esc_depth = '0;
	logic [7:0] esc_digit = '0;
	logic       in_value_part = 1'b0;
	logic       pair_open = 1'b0;

	form_urlencoded_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor of the decoder
	function automatic bit is_hex_digit(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] nibble_of(logic [7:0] c);
		logic [7:0] v;
		if (c >= "a")
			v = c - "a" + 8'd10;
		else if (c >= "A")
			v = c - "A" + 8'd10;
		else
			v = c - "0";
		return v[3:0];
	endfunction

	function automatic logic [1:0] part_kind();
		return in_value_part ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY;
	endfunction

	task automatic emit_decoded(logic [1:0] kind, logic [7:0] data, logic has_value);
		fud_pkg::out_item_t r;
		r.out_kind = kind;
		r.out_byte = data;
		r.pair_has_value = has_value;
		r.last_of_run = 1'b0;
		run_buf.push_back(r);
	endtask

	// held escape bytes go out literally
	task automatic flush_escape();
		if (esc_depth >= 2'd1)
			emit_decoded(part_kind(), CH_PCT, 1'b0);
		if (esc_depth >= 2'd2)
			emit_decoded(part_kind(), esc_digit, 1'b0);
		esc_depth = '0;
		esc_digit = '0;
	endtask

	task automatic feed_char(logic [7:0] c);
		bit done;
		done = 1'b0;
		if (esc_depth == 2'd1) begin
			if (is_hex_digit(c)) begin
				esc_digit = c;
				esc_depth = 2'd2;
				done = 1'b1;
			end else begin
				flush_escape();
			end
		end else if (esc_depth >= 2'd2) begin
			if (is_hex_digit(c)) begin
				emit_decoded(part_kind(), {nibble_of(esc_digit), nibble_of(c)}, 1'b0);
				esc_depth = '0;
				esc_digit = '0;
				done = 1'b1;
			end else begin
				flush_escape();
			end
		end
		if (!done) begin
			if (c == CH_PCT)
				esc_depth = 2'd1;
			else if (c == CH_PLUS)
				emit_decoded(part_kind(), CH_SPACE, 1'b0);
			else
				emit_decoded(part_kind(), c, 1'b0);
		end
	endtask

	task automatic end_pair();
		if (pair_open) begin
			flush_escape();
			emit_decoded(fud_pkg::KIND_END, 8'h00, in_value_part);
		end
		esc_depth = '0;
		esc_digit = '0;
		in_value_part = 1'b0;
		pair_open = 1'b0;
	endtask

	task automatic decode_byte(fud_pkg::in_item_t it);
		run_buf.delete();
		if (it.in_byte == CH_AMP) begin
			end_pair();
		end else begin
			pair_open = 1'b1;
			if (it.in_byte == CH_EQ && !in_value_part) begin
				flush_escape();
				in_value_part = 1'b1;
			end else begin
				feed_char(it.in_byte);
			end
		end
		if (it.is_end)
			end_pair();
		if (run_buf.size() > 0)
			run_buf[run_buf.size() - 1].last_of_run = 1'b1;
		foreach (run_buf[i])
			decoded_q.push_back(run_buf[i]);
	endtask

	// stimulus builders
	task automatic add_item(logic [7:0] b, bit e);
		stim_t s;
		s.item.in_byte = b;
		s.item.is_end = e;
		s.drain_first = drain_next;
		s.idle_pct = cur_idle;
		s.stall_pct = cur_stall;
		drain_next = 1'b0;
		stim_q.push_back(s);
	endtask

	function automatic logic [7:0] rand_hex();
		case ($urandom_range(2))
			0: return "0" + 8'($urandom_range(9));
			1: return "a" + 8'($urandom_range(5));
			default: return "A" + 8'($urandom_range(5));
		endcase
	endfunction

	function automatic logic [7:0] rand_non_hex();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (is_hex_digit(c));
		return c;
	endfunction

	// one body of pairs, mostly well formed, last byte flagged as end
	task automatic add_body();
		logic [7:0] body[$];
		int n_tok;
		int pick;
		n_tok = $urandom_range(1, 8);
		repeat (n_tok) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				body.push_back("a" + 8'($urandom_range(25)));
			end else if (pick < 38) begin
				body.push_back("0" + 8'($urandom_range(9)));
			end else if (pick < 46) begin
				body.push_back(CH_PLUS);
			end else if (pick < 62) begin
				body.push_back(CH_PCT);
				body.push_back(rand_hex());
				body.push_back(rand_hex());
			end else if (pick < 70) begin
				body.push_back(CH_PCT);
				if ($urandom_range(1))
					body.push_back(rand_hex());
				body.push_back($urandom_range(3) == 0 ? CH_PCT : rand_non_hex());
			end else if (pick < 80) begin
				body.push_back(CH_EQ);
			end else if (pick < 90) begin
				body.push_back(8'($urandom_range(255)));
			end else begin
				body.push_back(CH_AMP);
			end
		end
		// escape cut by the end of the body
		if ($urandom_range(9) == 0) begin
			body.push_back(CH_PCT);
			if ($urandom_range(1))
				body.push_back(rand_hex());
		end
		foreach (body[i])
			add_item(body[i], i == body.size() - 1);
	endtask

	task automatic add_noise();
		repeat ($urandom_range(1, 4))
			add_item(8'($urandom_range(255)), $urandom_range(3) == 0);
	endtask

	// sender: one transaction at a time from the stimulus queue
	always @(posedge clk) begin
		bit taken;
		bit launch;
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			taken = byte_valid && !byte_stall;
			if (taken)
				stim_q.delete(0);
			if (!(byte_valid && !taken)) begin
				launch = 1'b0;
				if (stim_q.size() > 0) begin
					launch = $urandom_range(99) >= stim_q[0].idle_pct;
					if (stim_q[0].drain_first)
						launch = launch && !byte_valid && outstanding == 0;
				end
				if (launch) begin
					byte_valid <= 1'b1;
					byte_item <= stim_q[0].item;
					stall_pct <= stim_q[0].stall_pct;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= $urandom_range(99) < stall_pct;
	end

	// checker: compare each result transaction, then predict the accepted byte
	always @(posedge clk) begin
		fud_pkg::out_item_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (decoded_q.size() == 0) begin
					$error("result with nothing expected: kind %0d byte %0h",
						res_item.out_kind, res_item.out_byte);
					fails++;
				end else begin
					want = decoded_q.pop_front();
					if (res_item.out_kind !== want.out_kind) begin
						$error("out_kind: expected %0d, got %0d", want.out_kind,
							res_item.out_kind);
						fails++;
					end
					if (res_item.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, got %0h", want.out_byte,
							res_item.out_byte);
						fails++;
					end
					if (res_item.pair_has_value !== want.pair_has_value) begin
						$error("pair_has_value: expected %0d, got %0d",
							want.pair_has_value, res_item.pair_has_value);
						fails++;
					end
					if (res_item.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d", want.last_of_run,
							res_item.last_of_run);
						fails++;
					end
					results_seen++;
					if (want.out_kind == fud_pkg::KIND_END)
						pairs_closed++;
				end
			end
			if (byte_valid && !byte_stall) begin
				decode_byte(byte_item);
				bytes_taken++;
			end
			outstanding <= decoded_q.size();
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		int idle_tab[4];
		int stall_tab[4];
		int start;
		idle_tab = '{0, 88, 0, 24};
		stall_tab = '{0, 0, 88, 24};

		// directed: leading and doubled '&', escapes cut and broken, extremes
		add_item(CH_AMP, 1'b0);
		add_item("a", 1'b0);
		add_item(CH_PCT, 1'b0);
		add_item("4", 1'b0);
		add_item(CH_EQ, 1'b0);
		add_item(CH_PLUS, 1'b0);
		add_item(CH_PCT, 1'b0);
		add_item("z", 1'b0);
		add_item(CH_EQ, 1'b0);
		add_item(CH_PCT, 1'b0);
		add_item(CH_PCT, 1'b0);
		add_item("6", 1'b0);
		add_item("a", 1'b0);
		add_item(CH_AMP, 1'b0);
		add_item(CH_AMP, 1'b0);
		add_item(8'h00, 1'b0);
		add_item(8'hff, 1'b0);
		add_item(CH_PCT, 1'b0);
		add_item("F", 1'b0);
		add_item(CH_AMP, 1'b0);
		add_item(CH_PCT, 1'b0);
		add_item("A", 1'b1);
		add_item(CH_PCT, 1'b0);
		add_item("c", 1'b0);
		add_item("q", 1'b1);
		add_item("x", 1'b0);
		add_item(CH_AMP, 1'b1);

		// random bodies and noise over the idle and stall phases
		for (int ph = 0; ph < 4; ph++) begin
			cur_idle = idle_tab[ph];
			cur_stall = stall_tab[ph];
			if (ph == 1 || ph == 2)
				drain_next = 1'b1;
			start = stim_q.size();
			while (stim_q.size() - start < PHASE_ITEMS) begin
				if ($urandom_range(6) == 0)
					add_noise();
				else
					add_body();
			end
		end

		// reset
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (stim_q.size() != 0 || outstanding != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (decoded_q.size() != 0) begin
			$error("%0d results never arrived", decoded_q.size());
			fails++;
		end
		$display("run: %0d bytes decoded, %0d results checked, %0d pairs closed",
			bytes_taken, results_seen, pairs_closed);
		$display("run: idle-free, sender-idle, receiver-stall and mixed phases");
		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
